/* src/sexp_tok_pkg.sv */
// ----------------------------------------------------------------------------
// sexp_tok_pkg
// Shared codes, types and character classes for the S-expression tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sexp_tok_pkg;

    localparam int DefIntWidth = 64;

    // Scan modes. The escape modes also exist offset by ChrOfs for char literals.
    localparam logic [4:0] M_TOP     = 5'd0;
    localparam logic [4:0] M_COMMENT = 5'd1;
    localparam logic [4:0] M_SIGN    = 5'd2;
    localparam logic [4:0] M_ZERO    = 5'd3;
    localparam logic [4:0] M_DIGITS  = 5'd4;
    localparam logic [4:0] M_IDENT   = 5'd5;
    localparam logic [4:0] M_STR     = 5'd6;
    localparam logic [4:0] M_CHR     = 5'd7;
    localparam logic [4:0] M_CLOSE   = 5'd8;
    localparam logic [4:0] M_ESC     = 5'd9;
    localparam logic [4:0] M_OCT     = 5'd10;
    localparam logic [4:0] M_HEX1    = 5'd11;
    localparam logic [4:0] M_HEX     = 5'd12;
    localparam logic [4:0] ChrOfs    = 5'd4;

    typedef logic [3:0] t_kind;
    localparam t_kind K_LPAREN = 4'd0;
    localparam t_kind K_RPAREN = 4'd1;
    localparam t_kind K_QUOTE  = 4'd2;
    localparam t_kind K_SBYTE  = 4'd3;
    localparam t_kind K_SEND   = 4'd4;
    localparam t_kind K_IBYTE  = 4'd5;
    localparam t_kind K_IEND   = 4'd6;
    localparam t_kind K_CHAR   = 4'd7;
    localparam t_kind K_INT    = 4'd8;
    localparam t_kind K_EOF    = 4'd9;
    localparam t_kind K_ERR    = 4'd10;

    typedef logic [2:0] t_err;
    localparam t_err E_NONE  = 3'd0;
    localparam t_err E_UNTERM = 3'd1;
    localparam t_err E_ESC   = 3'd2;
    localparam t_err E_CHAR  = 3'd3;
    localparam t_err E_NUM   = 3'd4;
    localparam t_err E_REAL  = 3'd5;

    localparam logic [1:0] R_BIN = 2'd0;
    localparam logic [1:0] R_OCT = 2'd1;
    localparam logic [1:0] R_DEC = 2'd2;
    localparam logic [1:0] R_HEX = 2'd3;

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h0C || b == 8'h0A || b == 8'h0D || b == 8'h09 ||
               b == 8'h0B || b == 8'h20;
    endfunction

    function automatic logic is_delim(input logic [7:0] b, input logic eof);
        return eof || is_space(b) || b == "\"" || b == "(" || b == ")" || b == "#";
    endfunction

    // Returns {valid, value} of b as a digit of the given radix.
    function automatic logic [4:0] digit_val(input logic [7:0] b, input logic [1:0] radix);
        logic [3:0] d;
        logic       v;
        d = 4'd0;
        v = 1'b0;
        if (b >= "0" && b <= "9") begin
            d = 4'(b - 8'h30);
            v = 1'b1;
        end else if (b >= "a" && b <= "f") begin
            d = 4'(b - 8'h57);
            v = 1'b1;
        end else if (b >= "A" && b <= "F") begin
            d = 4'(b - 8'h37);
            v = 1'b1;
        end
        case (radix)
            R_BIN:   v = v && d < 4'd2;
            R_OCT:   v = v && d < 4'd8;
            R_DEC:   v = v && d < 4'd10;
            default: v = v;
        endcase
        return {v, d};
    endfunction

endpackage

`default_nettype wire

/* src/s_expression_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// s_expression_tokenizer_unit
// Byte-serial S-expression lexer producing token events with a result buffer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | i_in_valid / o_in_ready | i_in_byte, i_end_of_input
//  output  | out       | o_out_valid/i_out_ready | o_token_kind, o_byte_value,
//          |           |                         | o_int_value, o_error_code,
//          |           |                         | o_last_of_run
//
// Each accepted byte is decoded in the cycle it is accepted; its zero to three
// events land in a three-entry result buffer and appear from the next cycle.
// A new byte is taken whenever the buffer is empty or its last event is being
// taken, so one byte per cycle while each byte makes at most one event and the
// output is not stalled; a byte making n events holds the port until all are taken.
// Reset is synchronous and clears the scanner state and the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module s_expression_tokenizer_unit #(
    parameter int INT_WIDTH = sexp_tok_pkg::DefIntWidth
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [7:0]                 i_in_byte,
    input  wire                        i_end_of_input,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output sexp_tok_pkg::t_kind        o_token_kind,
    output logic [7:0]                 o_byte_value,
    output logic signed [63:0]         o_int_value,
    output sexp_tok_pkg::t_err         o_error_code,
    output logic                       o_last_of_run
);
    import sexp_tok_pkg::*;

    logic [4:0]           r_mode, n_mode;
    logic [INT_WIDTH-1:0] r_acc, n_acc;
    logic [1:0]           r_radix, n_radix;
    logic                 r_neg, n_neg;
    logic [1:0]           r_edig, n_edig;
    logic [7:0]           r_eacc, n_eacc;
    logic [7:0]           r_held, n_held;

    t_kind               r_kind [3];
    logic [7:0]          r_byte [3];
    logic signed [63:0]  r_int  [3];
    t_err                r_err  [3];
    logic [1:0]          r_cnt, r_idx;

    t_kind               e_kind [3];
    logic [7:0]          e_byte [3];
    logic signed [63:0]  e_int  [3];
    t_err                e_err  [3];
    logic [1:0]          e_cnt;

    logic in_fire, out_fire, out_last;

    assign o_out_valid = r_cnt != 2'd0;
    assign out_last    = r_idx == r_cnt - 2'd1;
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_in_ready  = !o_out_valid || (i_out_ready && out_last);
    assign in_fire     = i_in_valid && o_in_ready;

    assign o_token_kind  = r_kind[r_idx];
    assign o_byte_value  = r_byte[r_idx];
    assign o_int_value   = r_int[r_idx];
    assign o_error_code  = r_err[r_idx];
    assign o_last_of_run = out_last;

    always_comb begin
        logic [7:0]  b;
        logic        eof, in_char, is_dig;
        logic [4:0]  base, dv5;
        logic        do_top, do_dig, do_ident, do_res, do_done, do_str, do_close, do_fail;
        logic [7:0]  rv, cv;
        t_err        fcode;
        logic [1:0]  ed;
        logic [INT_WIDTH-1:0] a, vu;
        logic signed [INT_WIDTH-1:0] vs;

        b       = i_in_byte;
        eof     = i_end_of_input;
        in_char = r_mode >= M_ESC + ChrOfs && r_mode <= M_HEX + ChrOfs;
        base    = in_char ? r_mode - ChrOfs : r_mode;
        is_dig  = !eof && b >= "0" && b <= "9";
        n_mode = r_mode; n_acc = r_acc; n_radix = r_radix; n_neg = r_neg;
        n_edig = r_edig; n_eacc = r_eacc; n_held = r_held;
        do_top = 1'b0; do_dig = 1'b0; do_ident = 1'b0; do_res = 1'b0;
        do_done = 1'b0; do_str = 1'b0; do_close = 1'b0; do_fail = 1'b0;
        rv = 8'd0; cv = 8'd0; fcode = E_NONE; dv5 = 5'd0; ed = 2'd0;
        a = '0; vu = '0; vs = '0;
        e_cnt = 2'd0;
        for (int k = 0; k < 3; k++) begin
            e_kind[k] = K_LPAREN; e_byte[k] = 8'd0; e_int[k] = '0; e_err[k] = E_NONE;
        end

        unique case (base)
            M_COMMENT: begin
                if (eof) begin
                    e_kind[e_cnt] = K_EOF; e_cnt = e_cnt + 2'd1;
                end else if (b == 8'h0A) begin
                    n_mode = M_TOP;
                end
            end
            M_SIGN: begin
                if (is_dig) begin
                    n_neg = r_held == "-";
                    n_radix = R_DEC;
                    n_acc = INT_WIDTH'(b - 8'h30);
                    n_mode = (b == "0") ? M_ZERO : M_DIGITS;
                end else begin
                    e_kind[e_cnt] = K_IBYTE; e_byte[e_cnt] = r_held; e_cnt = e_cnt + 2'd1;
                    n_mode = M_IDENT;
                    do_ident = 1'b1;
                end
            end
            M_ZERO: begin
                n_mode = M_DIGITS;
                if (!eof && (b == "b" || b == "B")) n_radix = R_BIN;
                else if (!eof && (b == "o" || b == "O")) n_radix = R_OCT;
                else if (!eof && (b == "d" || b == "D")) n_radix = R_DEC;
                else if (!eof && (b == "x" || b == "X")) n_radix = R_HEX;
                else do_dig = 1'b1;
            end
            M_DIGITS: do_dig = 1'b1;
            M_IDENT:  do_ident = 1'b1;
            M_STR:    do_str = 1'b1;
            M_CHR: begin
                if (eof) begin
                    do_fail = 1'b1; fcode = E_CHAR;
                end else if (b == "\\") begin
                    n_mode = M_ESC + ChrOfs;
                end else begin
                    n_eacc = b;
                    n_mode = M_CLOSE;
                end
            end
            M_CLOSE: begin
                do_close = 1'b1; cv = r_eacc;
            end
            M_ESC: begin
                if (eof) begin
                    do_fail = 1'b1; fcode = in_char ? E_CHAR : E_UNTERM;
                end else begin
                    do_done = 1'b1;
                    case (b)
                        "a": rv = 8'h07;
                        "b": rv = 8'h08;
                        "e": rv = 8'h1B;
                        "f": rv = 8'h0C;
                        "n": rv = 8'h0A;
                        "r": rv = 8'h0D;
                        "t": rv = 8'h09;
                        "v": rv = 8'h0B;
                        "x": begin
                            do_done = 1'b0;
                            n_mode = in_char ? M_HEX1 + ChrOfs : M_HEX1;
                        end
                        "u", "U": begin
                            do_done = 1'b0;
                            do_fail = 1'b1; fcode = E_ESC;
                        end
                        default: begin
                            if (b >= "0" && b <= "7") begin
                                do_done = 1'b0;
                                n_eacc = b - 8'h30;
                                n_edig = 2'd1;
                                n_mode = in_char ? M_OCT + ChrOfs : M_OCT;
                            end else begin
                                rv = b;
                            end
                        end
                    endcase
                end
            end
            M_OCT: begin
                if (!eof && b >= "0" && b <= "7") begin
                    n_eacc = {r_eacc[4:0], 3'd0} + (b - 8'h30);
                    ed = r_edig + 2'd1;
                    n_edig = ed;
                    if (ed == 2'd3 || ed == 2'd0) begin
                        do_done = 1'b1; rv = n_eacc;
                    end
                end else begin
                    do_res = 1'b1; rv = r_eacc;
                end
            end
            M_HEX1: begin
                dv5 = digit_val(b, R_HEX);
                if (!eof && dv5[4]) begin
                    n_eacc = {4'd0, dv5[3:0]};
                    n_mode = in_char ? M_HEX + ChrOfs : M_HEX;
                end else begin
                    do_res = 1'b1; rv = "x";
                end
            end
            M_HEX: begin
                dv5 = digit_val(b, R_HEX);
                if (!eof && dv5[4]) begin
                    n_eacc = {r_eacc[3:0], dv5[3:0]};
                end else begin
                    do_res = 1'b1; rv = r_eacc;
                end
            end
            default: do_top = 1'b1;
        endcase

        if (do_dig) begin
            dv5 = digit_val(b, r_radix);
            if (!eof && dv5[4]) begin
                case (r_radix)
                    R_BIN:   a = {r_acc[INT_WIDTH-2:0], 1'b0};
                    R_OCT:   a = {r_acc[INT_WIDTH-4:0], 3'd0};
                    R_DEC:   a = {r_acc[INT_WIDTH-4:0], 3'd0} + {r_acc[INT_WIDTH-2:0], 1'b0};
                    default: a = {r_acc[INT_WIDTH-5:0], 4'd0};
                endcase
                n_acc = a + INT_WIDTH'(dv5[3:0]);
            end else if (!eof && (b == "." || b == "e" || b == "E")) begin
                do_fail = 1'b1; fcode = E_REAL;
            end else if (is_delim(b, eof)) begin
                vu = r_neg ? -r_acc : r_acc;
                vs = signed'(vu);
                e_kind[e_cnt] = K_INT; e_int[e_cnt] = 64'(vs); e_cnt = e_cnt + 2'd1;
                do_top = 1'b1;
            end else begin
                do_fail = 1'b1; fcode = E_NUM;
            end
        end

        if (do_ident) begin
            if (is_delim(b, eof)) begin
                e_kind[e_cnt] = K_IEND; e_cnt = e_cnt + 2'd1;
                do_top = 1'b1;
            end else begin
                e_kind[e_cnt] = K_IBYTE; e_byte[e_cnt] = b; e_cnt = e_cnt + 2'd1;
            end
        end

        // A terminated escape gives its byte, then the byte that ended it is
        // handled as ordinary string or char-close input.
        if (do_res) begin
            n_edig = 2'd0;
            if (in_char) begin
                do_close = 1'b1; cv = rv;
            end else begin
                e_kind[e_cnt] = K_SBYTE; e_byte[e_cnt] = rv; e_cnt = e_cnt + 2'd1;
                do_str = 1'b1;
            end
        end

        if (do_done) begin
            n_edig = 2'd0;
            if (in_char) begin
                n_eacc = rv;
                n_mode = M_CLOSE;
            end else begin
                e_kind[e_cnt] = K_SBYTE; e_byte[e_cnt] = rv; e_cnt = e_cnt + 2'd1;
                n_mode = M_STR;
            end
        end

        if (do_str) begin
            n_mode = M_STR;
            if (eof) begin
                do_fail = 1'b1; fcode = E_UNTERM;
            end else if (b == "\"") begin
                e_kind[e_cnt] = K_SEND; e_cnt = e_cnt + 2'd1;
                n_mode = M_TOP;
            end else if (b == "\\") begin
                n_mode = M_ESC;
            end else begin
                e_kind[e_cnt] = K_SBYTE; e_byte[e_cnt] = b; e_cnt = e_cnt + 2'd1;
            end
        end

        if (do_close) begin
            if (!eof && b == "'") begin
                e_kind[e_cnt] = K_CHAR; e_byte[e_cnt] = cv; e_cnt = e_cnt + 2'd1;
                n_mode = M_TOP;
            end else begin
                do_fail = 1'b1; fcode = E_CHAR;
            end
        end

        if (do_fail) begin
            e_kind[e_cnt] = K_ERR; e_err[e_cnt] = fcode; e_cnt = e_cnt + 2'd1;
            n_mode = M_TOP;
            n_edig = 2'd0;
        end

        if (do_top) begin
            n_mode = M_TOP;
            if (eof) begin
                e_kind[e_cnt] = K_EOF; e_cnt = e_cnt + 2'd1;
            end else if (!is_space(b)) begin
                case (b)
                    "#":  n_mode = M_COMMENT;
                    "\\": begin e_kind[e_cnt] = K_QUOTE;  e_cnt = e_cnt + 2'd1; end
                    "(":  begin e_kind[e_cnt] = K_LPAREN; e_cnt = e_cnt + 2'd1; end
                    ")":  begin e_kind[e_cnt] = K_RPAREN; e_cnt = e_cnt + 2'd1; end
                    "\"": n_mode = M_STR;
                    "'":  n_mode = M_CHR;
                    "+", "-": begin
                        n_held = b;
                        n_mode = M_SIGN;
                    end
                    default: begin
                        if (is_dig) begin
                            n_neg = 1'b0;
                            n_radix = R_DEC;
                            n_acc = INT_WIDTH'(b - 8'h30);
                            n_mode = (b == "0") ? M_ZERO : M_DIGITS;
                        end else begin
                            e_kind[e_cnt] = K_IBYTE; e_byte[e_cnt] = b;
                            e_cnt = e_cnt + 2'd1;
                            n_mode = M_IDENT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_TOP;
            r_acc   <= '0;
            r_radix <= R_DEC;
            r_neg   <= 1'b0;
            r_edig  <= 2'd0;
            r_eacc  <= 8'd0;
            r_held  <= 8'd0;
            r_cnt   <= 2'd0;
            r_idx   <= 2'd0;
        end else begin
            if (in_fire) begin
                r_mode  <= n_mode;
                r_acc   <= n_acc;
                r_radix <= n_radix;
                r_neg   <= n_neg;
                r_edig  <= n_edig;
                r_eacc  <= n_eacc;
                r_held  <= n_held;
                r_cnt   <= e_cnt;
                r_idx   <= 2'd0;
            end else if (out_fire) begin
                if (out_last) begin
                    r_cnt <= 2'd0;
                    r_idx <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_kind[k] <= e_kind[k];
                r_byte[k] <= e_byte[k];
                r_int[k]  <= e_int[k];
                r_err[k]  <= e_err[k];
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_idx < r_cnt)
        else $error("result index beyond buffered count");

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 || r_idx <= 2'd2)
        else $error("result buffer overrun");

    a_ready_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_ready) |-> (o_last_of_run && i_out_ready))
        else $error("new request taken while earlier results remain");

    a_events_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && e_cnt != 2'd0) |=> o_out_valid && r_idx == 2'd0)
        else $error("events of a request were not presented");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == K_ERR) |-> o_error_code != E_NONE)
        else $error("error event without a code");

endmodule

`default_nettype wire
